// ----- rtl/wlrs_pkg.sv -----
// ----------------------------------------------------------------------------
// wlrs_pkg
// Shared constants and types for the wear-leveled record store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wlrs_pkg;

  localparam int SLOT_COUNT   = 16;
  localparam int RECORD_WIDTH = 64;
  localparam int SLOT_W       = (SLOT_COUNT > 2) ? $clog2(SLOT_COUNT) : 1;
  localparam int REC_OUT_W    = 64;
  localparam int SLOT_OUT_W   = 4;

  typedef logic [SLOT_W-1:0]       slot_t;
  typedef logic [RECORD_WIDTH-1:0] rec_t;
  typedef logic [REC_OUT_W-1:0]    rec_out_t;
  typedef logic [SLOT_OUT_W-1:0]   slot_out_t;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_SAVE = 1'b1;

  typedef enum logic [1:0] {
    MARK_ERASED,
    MARK_LAST,
    MARK_NEXT
  } mark_t;

  typedef struct packed {
    logic save;
    logic scan_clr;
    logic scan_step;
    logic fetch;
    logic capture;
    logic deliver;
  } ctl_t;

  typedef struct packed {
    logic hit;
    logic at_end;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ----- rtl/wlrs_cmd_if.sv -----
// ----------------------------------------------------------------------------
// wlrs_cmd_if
// Request channel: opcode and record, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface wlrs_cmd_if;
  logic valid;
  logic ready;
  logic opcode;
  logic [63:0] record_in;

  modport source (output valid, output opcode, output record_in, input ready);
  modport sink (input valid, input opcode, input record_in, output ready);
endinterface

`default_nettype wire

// ----- rtl/wlrs_rsp_if.sv -----
// ----------------------------------------------------------------------------
// wlrs_rsp_if
// Result channel: record and slot index, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface wlrs_rsp_if;
  logic valid;
  logic ready;
  logic [63:0] record_out;
  logic [3:0] slot_index;

  modport source (output valid, output record_out, output slot_index, input ready);
  modport sink (input valid, input record_out, input slot_index, output ready);
endinterface

`default_nettype wire

// ----- rtl/wlrs_ctrl.sv -----
// ----------------------------------------------------------------------------
// wlrs_ctrl
// Sequencer: accepts requests, walks the load scan, hands results to output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wlrs_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cmd_valid,
  input  wire logic            cmd_opcode,
  output logic                 cmd_ready,
  input  wire wlrs_pkg::stat_t stat,
  output wlrs_pkg::ctl_t       ctl
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FETCH = 2'd2;
  localparam logic [1:0] S_HOLD  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    cmd_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          if (cmd_opcode == wlrs_pkg::OP_SAVE) begin
            ctl.save   = 1'b1;
            state_next = S_HOLD;
          end else begin
            ctl.scan_clr = 1'b1;
            state_next   = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (stat.hit || stat.at_end) begin
          ctl.fetch  = 1'b1;
          state_next = S_FETCH;
        end else begin
          ctl.scan_step = 1'b1;
        end
      end
      S_FETCH: begin
        ctl.capture = 1'b1;
        state_next  = S_HOLD;
      end
      S_HOLD: begin
        if (stat.out_free) begin
          ctl.deliver = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/wlrs_dpath.sv -----
// ----------------------------------------------------------------------------
// wlrs_dpath
// Datapath: record memory, status marks, slot pointer, scan counter and
// output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wlrs_dpath (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire wlrs_pkg::ctl_t  ctl,
  output wlrs_pkg::stat_t      stat,
  input  wire logic [63:0]     record_in,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [63:0]          record_out,
  output logic [3:0]           slot_index
);

  function automatic wlrs_pkg::slot_t wrap_next(input wlrs_pkg::slot_t s);
    logic [wlrs_pkg::SLOT_W-1:0] nxt;
    nxt = (s == wlrs_pkg::slot_t'(wlrs_pkg::SLOT_COUNT - 1)) ? '0 : s + 1'b1;
    return nxt;
  endfunction

  wlrs_pkg::rec_t  mem [wlrs_pkg::SLOT_COUNT];
  logic [wlrs_pkg::SLOT_COUNT-1:0] written;
  wlrs_pkg::mark_t marks [wlrs_pkg::SLOT_COUNT];
  logic [wlrs_pkg::SLOT_COUNT-1:0] pair;

  wlrs_pkg::slot_t cur;
  wlrs_pkg::slot_t idx;
  wlrs_pkg::slot_t save_slot;
  wlrs_pkg::slot_t found;
  wlrs_pkg::rec_t  rdata;
  logic            rvalid;
  wlrs_pkg::rec_t  res_record;
  wlrs_pkg::slot_t res_slot;
  wlrs_pkg::rec_t  rec_masked;

  assign rec_masked = record_in[wlrs_pkg::RECORD_WIDTH-1:0];
  assign save_slot  = wrap_next(cur);

  for (genvar i = 0; i < wlrs_pkg::SLOT_COUNT; i++) begin : g_pair
    localparam int NXT = (i + 1) % wlrs_pkg::SLOT_COUNT;
    assign pair[i] = (marks[i] == wlrs_pkg::MARK_LAST) && (marks[NXT] == wlrs_pkg::MARK_NEXT);
  end

  assign stat.hit      = pair[idx];
  assign stat.at_end   = (idx == wlrs_pkg::slot_t'(wlrs_pkg::SLOT_COUNT - 1));
  assign stat.out_free = !out_valid || out_ready;
  assign found         = pair[idx] ? idx : '0;

  // record memory
  always_ff @(posedge clk) begin
    if (ctl.save) begin
      mem[save_slot] <= rec_masked;
    end
    if (ctl.fetch) begin
      rdata <= mem[found];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      cur     <= '0;
      idx     <= '0;
      rvalid  <= 1'b0;
      for (int i = 0; i < wlrs_pkg::SLOT_COUNT; i++) begin
        marks[i] <= wlrs_pkg::MARK_ERASED;
      end
    end else begin
      if (ctl.save) begin
        written[save_slot]        <= 1'b1;
        cur                       <= save_slot;
        marks[save_slot]          <= wlrs_pkg::MARK_LAST;
        marks[wrap_next(save_slot)] <= wlrs_pkg::MARK_NEXT;
      end
      if (ctl.scan_clr) begin
        idx <= '0;
      end else if (ctl.scan_step) begin
        idx <= idx + 1'b1;
      end
      if (ctl.fetch) begin
        cur    <= found;
        rvalid <= written[found];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.save) begin
      res_record <= rec_masked;
      res_slot   <= save_slot;
    end
    if (ctl.fetch) begin
      res_slot <= found;
    end
    if (ctl.capture) begin
      res_record <= rvalid ? rdata : '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.deliver) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.deliver) begin
      record_out <= wlrs_pkg::rec_out_t'(res_record);
      slot_index <= wlrs_pkg::slot_out_t'(res_slot);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/wear_leveled_record_store_unit.sv -----
// ----------------------------------------------------------------------------
// wear_leveled_record_store_unit
// Ring of record slots with status marks for wear leveling.
//
// Channels: cmd (sink) carries opcode and record_in; rsp (source) carries
// record_out and slot_index. Both transfer on valid && ready.
// A save (opcode 1) advances the slot pointer, stores the record and marks
// the slot as last; its result is the stored record and the slot number.
// A load (opcode 0) scans the status marks from slot 0 for a last mark
// followed by a next mark, falls back to slot 0 if none, and returns that
// slot's record.
// A load scans the marks one entry per cycle from slot 0, so it takes longer
// the further its slot lies from slot 0. One item is in work at a time.
// A finished result is loaded into the output register once that register
// is free. The next request is accepted while a result waits.
// Reset (synchronous, rst high) erases all marks, clears the written flags
// (unwritten slots load as zero), sets the pointer to 0 and empties the
// output register. A stalled receiver holds the result; a finished item
// waits for the output register before the next request is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wear_leveled_record_store_unit (
  input wire logic clk,
  input wire logic rst,
  wlrs_cmd_if.sink cmd,
  wlrs_rsp_if.source rsp
);

  wlrs_pkg::ctl_t  ctl;
  wlrs_pkg::stat_t stat;

  wlrs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd.valid),
    .cmd_opcode (cmd.opcode),
    .cmd_ready  (cmd.ready),
    .stat       (stat),
    .ctl        (ctl)
  );

  wlrs_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .stat       (stat),
    .record_in  (cmd.record_in),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .record_out (rsp.record_out),
    .slot_index (rsp.slot_index)
  );

endmodule

`default_nettype wire

// ----- rtl/wlrs_checker.sv -----
// ----------------------------------------------------------------------------
// wlrs_checker
// Port-level checks for the record store, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wlrs_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cmd_valid,
  input wire logic        cmd_ready,
  input wire logic        cmd_opcode,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [63:0] rsp_record,
  input wire logic [3:0]  rsp_slot
);

  logic save_xfer;
  assign save_xfer = cmd_valid && cmd_ready && (cmd_opcode == wlrs_pkg::OP_SAVE);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_record) && $stable(rsp_slot))
    else $error("result dropped or changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result shown right after reset");

  a_save_busy: assert property (@(posedge clk) disable iff (rst)
    save_xfer |=> !cmd_ready)
    else $error("request taken during a save");

  a_save_result: assert property (@(posedge clk) disable iff (rst)
    save_xfer |-> ##2 rsp_valid)
    else $error("save result missing");

endmodule

bind wear_leveled_record_store_unit wlrs_checker u_wlrs_checker (
  .clk        (clk),
  .rst        (rst),
  .cmd_valid  (cmd.valid),
  .cmd_ready  (cmd.ready),
  .cmd_opcode (cmd.opcode),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_record (rsp.record_out),
  .rsp_slot   (rsp.slot_index)
);

`default_nettype wire
